FILE: hdl/assert_macros.svh
// Assertion macros used by the checker of the pump run supervisor.
// Every macro wraps one concurrent assertion clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/prs_pkg.sv
// Package of the pump run supervisor: field widths, event, state and reason
// codes, register indexes and the result beat structure. No dependencies.
`default_nettype none

package prs_pkg;

  localparam int unsigned SEC_W   = 16;
  localparam int unsigned MA_W    = 16;
  localparam int unsigned GRACE_W = 8;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] run_state_t;
  typedef logic [2:0] reason_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam mode_t MODE_TICK  = 2'd0;
  localparam mode_t MODE_START = 2'd1;
  localparam mode_t MODE_STOP  = 2'd2;
  localparam mode_t MODE_RESET = 2'd3;

  localparam run_state_t ST_IDLE  = 2'd0;
  localparam run_state_t ST_RUN   = 2'd1;
  localparam run_state_t ST_BLOCK = 2'd2;

  localparam reason_t RS_NONE     = 3'd0;
  localparam reason_t RS_DURATION = 3'd1;
  localparam reason_t RS_MANUAL   = 3'd2;
  localparam reason_t RS_TANK     = 3'd3;
  localparam reason_t RS_MAXRUN   = 3'd4;
  localparam reason_t RS_OVERCUR  = 3'd5;
  localparam reason_t RS_DRY      = 3'd6;
  localparam reason_t RS_INVALID  = 3'd7;

  localparam cfg_idx_t CFG_DEFAULT_DURATION = 3'd0;
  localparam cfg_idx_t CFG_MAX_RUNTIME      = 3'd1;
  localparam cfg_idx_t CFG_DRY_RUN_MA       = 3'd2;
  localparam cfg_idx_t CFG_OVERCURRENT_MA   = 3'd3;
  localparam cfg_idx_t CFG_DRY_RUN_GRACE    = 3'd4;

  localparam logic [SEC_W-1:0]   RST_DEFAULT_DURATION = 16'd60;
  localparam logic [SEC_W-1:0]   RST_MAX_RUNTIME      = 16'd600;
  localparam logic [MA_W-1:0]    RST_DRY_RUN_MA       = 16'd50;
  localparam logic [MA_W-1:0]    RST_OVERCURRENT_MA   = 16'd3000;
  localparam logic [GRACE_W-1:0] RST_DRY_RUN_GRACE    = 8'd3;

  typedef struct packed {
    logic              pump_on;
    run_state_t        pump_state;
    logic              start_accepted;
    reason_t           stop_reason;
    logic              safety_trip;
    logic              failsafe_active;
    logic [SEC_W-1:0]  last_run_seconds;
    logic [CNT_W-1:0]  cycle_count;
    logic [SEC_W-1:0]  elapsed_seconds;
    logic              mismatch_alert;
    logic [MA_W-1:0]   last_current;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/prs_in_if.sv
// Input event channel of the pump run supervisor: valid, ready and payload.
// Depends on prs_pkg for the field types.
`default_nettype none

interface prs_in_if
  import prs_pkg::*;
();
  logic             valid;
  logic             ready;
  mode_t            mode;
  logic [SEC_W-1:0] duration_request;
  reason_t          stop_cause;
  logic             tank_critical;
  logic [MA_W-1:0]  current_ma;
  logic             current_valid;
  logic             levels_match;

  modport source (output valid, mode, duration_request, stop_cause, tank_critical,
                  current_ma, current_valid, levels_match, input ready);
  modport sink   (input valid, mode, duration_request, stop_cause, tank_critical,
                  current_ma, current_valid, levels_match, output ready);
endinterface

`default_nettype wire

FILE: hdl/prs_out_if.sv
// Result channel of the pump run supervisor: valid, ready and payload.
// Depends on prs_pkg for the field types.
`default_nettype none

interface prs_out_if
  import prs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             pump_on;
  run_state_t       pump_state;
  logic             start_accepted;
  reason_t          stop_reason;
  logic             safety_trip;
  logic             failsafe_active;
  logic [SEC_W-1:0] last_run_seconds;
  logic [CNT_W-1:0] cycle_count;
  logic [SEC_W-1:0] elapsed_seconds;
  logic             mismatch_alert;
  logic [MA_W-1:0]  last_current;

  modport source (output valid, pump_on, pump_state, start_accepted, stop_reason,
                  safety_trip, failsafe_active, last_run_seconds, cycle_count,
                  elapsed_seconds, mismatch_alert, last_current, input ready);
  modport sink   (input valid, pump_on, pump_state, start_accepted, stop_reason,
                  safety_trip, failsafe_active, last_run_seconds, cycle_count,
                  elapsed_seconds, mismatch_alert, last_current, output ready);
endinterface

`default_nettype wire

FILE: hdl/pump_run_supervisor_top.sv
// A result beat appears in the cycle after its event beat is accepted.
// One event per cycle unless stalled; the state update and the result register
// are written at the accepting edge, and the result register is the only buffer.
// A new event is taken while the held result is being taken in the same cycle.
// Reset (synchronous, rst_n low) sets idle, clears the latch, counters and
// reason, and loads the configuration registers with their defaults.
`default_nettype none

module pump_run_supervisor_top
  import prs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  prs_in_if.sink                     in_ch,
  prs_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire cfg_idx_t              cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [SEC_W-1:0]   def_dur_r;
  logic [SEC_W-1:0]   max_run_r;
  logic [MA_W-1:0]    dry_ma_r;
  logic [MA_W-1:0]    oc_ma_r;
  logic [GRACE_W-1:0] grace_r;

  run_state_t        state_r, state_nxt;
  logic              latch_r, latch_nxt;
  logic [SEC_W-1:0]  run_sec_r, run_sec_nxt;
  logic [SEC_W-1:0]  target_r, target_nxt;
  reason_t           reason_r, reason_nxt;
  logic [SEC_W-1:0]  last_dur_r, last_dur_nxt;
  logic [CNT_W-1:0]  runs_r, runs_nxt;
  logic [MA_W-1:0]   sample_r, sample_nxt;

  logic              out_valid_r;
  result_t           res_r, res_nxt;

  logic              accept;
  logic              accepted, trip, alert;
  logic              do_end, blocks;
  reason_t           why;
  logic [SEC_W-1:0]  run_sec_inc;
  logic [SEC_W-1:0]  req_dur;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign run_sec_inc = (run_sec_r == {SEC_W{1'b1}}) ? run_sec_r : run_sec_r + 16'd1;
  assign req_dur     = (in_ch.duration_request != '0) ? in_ch.duration_request : def_dur_r;

  always_comb begin
    state_nxt    = state_r;
    latch_nxt    = latch_r;
    run_sec_nxt  = run_sec_r;
    target_nxt   = target_r;
    reason_nxt   = reason_r;
    last_dur_nxt = last_dur_r;
    runs_nxt     = runs_r;
    sample_nxt   = sample_r;
    accepted     = 1'b0;
    trip         = 1'b0;
    alert        = 1'b0;
    do_end       = 1'b0;
    why          = RS_NONE;

    case (in_ch.mode)
      MODE_TICK: begin
        if (state_r == ST_RUN) begin
          run_sec_nxt = run_sec_inc;
          if (run_sec_inc >= target_r) begin
            do_end = 1'b1;
            why    = RS_DURATION;
          end else if (run_sec_inc >= max_run_r) begin
            do_end = 1'b1;
            why    = RS_MAXRUN;
          end else if (in_ch.tank_critical) begin
            do_end = 1'b1;
            why    = RS_TANK;
          end else begin
            sample_nxt = in_ch.current_ma;
            if (in_ch.current_valid && (in_ch.current_ma < dry_ma_r) &&
                (run_sec_inc > {{(SEC_W-GRACE_W){1'b0}}, grace_r})) begin
              do_end = 1'b1;
              why    = RS_DRY;
              trip   = 1'b1;
            end else if (in_ch.current_valid && (in_ch.current_ma > oc_ma_r)) begin
              do_end = 1'b1;
              why    = RS_OVERCUR;
              trip   = 1'b1;
            end else if (!in_ch.levels_match) begin
              alert = 1'b1;
            end
          end
        end
      end
      MODE_START: begin
        if (!latch_r) begin
          if (in_ch.tank_critical) begin
            state_nxt   = ST_BLOCK;
            latch_nxt   = 1'b1;
            reason_nxt  = RS_TANK;
            run_sec_nxt = '0;
          end else begin
            target_nxt  = (req_dur > max_run_r) ? max_run_r : req_dur;
            run_sec_nxt = '0;
            state_nxt   = ST_RUN;
            runs_nxt    = runs_r + 32'd1;
            accepted    = 1'b1;
          end
        end
      end
      MODE_STOP: begin
        do_end = 1'b1;
        why    = (in_ch.stop_cause == RS_INVALID) ? RS_MANUAL : in_ch.stop_cause;
      end
      MODE_RESET: begin
        latch_nxt = 1'b0;
        if (state_r != ST_RUN) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
      end
    endcase

    blocks = (why == RS_TANK) || (why == RS_OVERCUR) || (why == RS_DRY);
    if (do_end) begin
      last_dur_nxt = (state_r == ST_RUN) ? run_sec_nxt : '0;
      reason_nxt   = why;
      state_nxt    = blocks ? ST_BLOCK : ST_IDLE;
      if (blocks) begin
        latch_nxt = 1'b1;
      end
      run_sec_nxt = '0;
    end

    res_nxt.pump_on          = (state_nxt == ST_RUN);
    res_nxt.pump_state       = state_nxt;
    res_nxt.start_accepted   = accepted;
    res_nxt.stop_reason      = reason_nxt;
    res_nxt.safety_trip      = trip;
    res_nxt.failsafe_active  = latch_nxt;
    res_nxt.last_run_seconds = last_dur_nxt;
    res_nxt.cycle_count      = runs_nxt;
    res_nxt.elapsed_seconds  = (state_nxt == ST_RUN) ? run_sec_nxt : '0;
    res_nxt.mismatch_alert   = alert;
    res_nxt.last_current     = sample_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_dur_r <= RST_DEFAULT_DURATION;
      max_run_r <= RST_MAX_RUNTIME;
      dry_ma_r  <= RST_DRY_RUN_MA;
      oc_ma_r   <= RST_OVERCURRENT_MA;
      grace_r   <= RST_DRY_RUN_GRACE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEFAULT_DURATION: def_dur_r <= cfg_wdata;
        CFG_MAX_RUNTIME:      max_run_r <= cfg_wdata;
        CFG_DRY_RUN_MA:       dry_ma_r  <= cfg_wdata;
        CFG_OVERCURRENT_MA:   oc_ma_r   <= cfg_wdata;
        CFG_DRY_RUN_GRACE:    grace_r   <= cfg_wdata[GRACE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      latch_r    <= 1'b0;
      run_sec_r  <= '0;
      target_r   <= '0;
      reason_r   <= RS_NONE;
      last_dur_r <= '0;
      runs_r     <= '0;
      sample_r   <= '0;
    end else if (accept) begin
      state_r    <= state_nxt;
      latch_r    <= latch_nxt;
      run_sec_r  <= run_sec_nxt;
      target_r   <= target_nxt;
      reason_r   <= reason_nxt;
      last_dur_r <= last_dur_nxt;
      runs_r     <= runs_nxt;
      sample_r   <= sample_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.pump_on          = res_r.pump_on;
  assign out_ch.pump_state       = res_r.pump_state;
  assign out_ch.start_accepted   = res_r.start_accepted;
  assign out_ch.stop_reason      = res_r.stop_reason;
  assign out_ch.safety_trip      = res_r.safety_trip;
  assign out_ch.failsafe_active  = res_r.failsafe_active;
  assign out_ch.last_run_seconds = res_r.last_run_seconds;
  assign out_ch.cycle_count      = res_r.cycle_count;
  assign out_ch.elapsed_seconds  = res_r.elapsed_seconds;
  assign out_ch.mismatch_alert   = res_r.mismatch_alert;
  assign out_ch.last_current     = res_r.last_current;

endmodule

`default_nettype wire

FILE: hdl/prs_checker.sv
// Port-level checker of the pump run supervisor and its bind to the top level.
// Depends on prs_pkg and on the macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module prs_checker
  import prs_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             pump_on,
  input wire run_state_t       pump_state,
  input wire logic             start_accepted,
  input wire reason_t          stop_reason,
  input wire logic             safety_trip,
  input wire logic             failsafe_active,
  input wire logic [SEC_W-1:0] elapsed_seconds
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pump_state) && $stable(stop_reason), "result beat changed while stalled")
  `ASSERT_IMPL(a_pump_on_state, clk, rst_n, out_valid, pump_on == (pump_state == ST_RUN), "pump_on disagrees with pump_state")
  `ASSERT_IMPL(a_elapsed_idle, clk, rst_n, out_valid && !pump_on, elapsed_seconds == '0, "elapsed seconds nonzero while not running")
  `ASSERT_IMPL(a_start_runs, clk, rst_n, out_valid && start_accepted, pump_on && !safety_trip, "accepted start did not leave the pump running")
  `ASSERT_IMPL(a_trip_blocks, clk, rst_n, out_valid && safety_trip, failsafe_active && (pump_state == ST_BLOCK) && ((stop_reason == RS_DRY) || (stop_reason == RS_OVERCUR)), "safety trip without block and latch")

endmodule

bind pump_run_supervisor_top prs_checker u_prs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .pump_on         (out_ch.pump_on),
  .pump_state      (out_ch.pump_state),
  .start_accepted  (out_ch.start_accepted),
  .stop_reason     (out_ch.stop_reason),
  .safety_trip     (out_ch.safety_trip),
  .failsafe_active (out_ch.failsafe_active),
  .elapsed_seconds (out_ch.elapsed_seconds)
);

`default_nettype wire
